// ===== rtl/core/dhoat_pkg.sv =====
// Package for the double-hashing open-address table.
// Holds widths, codes, channel payload structs and the control state type.
// No dependencies.
package dhoat_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CFG_W       = 11;
   localparam int KEY_W       = 31;
   localparam int BITCNT_W    = $clog2(KEY_W);
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MODULUS = 1'b1;

   localparam logic [CFG_W-1:0] TABLE_SIZE_RST   = CFG_W'(TABLE_DEPTH);
   localparam logic [CFG_W-1:0] STEP_MODULUS_RST = CFG_W'(1);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_FOUND     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_BAD_KEY   = 3'd4
   } status_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] slot;
      logic [CFG_W-1:0]  collisions;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_STEP,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

endpackage

// ===== rtl/core/dhoat_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module dhoat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/double_hash_open_address_table.sv =====
// Top level of the double-hashing open-address table.
// Depends on dhoat_pkg and dhoat_ram.
//
// Hash table of TABLE_DEPTH 31-bit buckets in one single-port RAM; zero marks an empty
// bucket. After reset the block sweeps the RAM to zero, one bucket a cycle, with req_ready
// low; CSR writes are taken during the sweep. One request is worked at a time. A zero key
// goes straight to the done state and answers with bad-key status. Any other key is
// accepted, then a bit-serial remainder gives key mod size and key mod step_modulus, a
// second bit-serial remainder reduces the probe step mod size, then each probe reads the
// RAM and then compares and optionally writes, and last the response register is loaded.
// A response may wait in its register while the next request is accepted.
module double_hash_open_address_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dhoat_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dhoat_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [dhoat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dhoat_pkg::CFG_W-1:0]         csr_wdata
);
   import dhoat_pkg::*;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [CFG_W-1:0]    table_size_ff, table_size_in;
   logic [CFG_W-1:0]    step_mod_ff, step_mod_in;
   op_type              op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    sh_ff, sh_in;
   logic [BITCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [CFG_W-1:0]    rem_m_ff, rem_m_in;
   logic [CFG_W-1:0]    rem_q_ff, rem_q_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   step_ff, step_in;
   logic [CFG_W-1:0]    probe_ff, probe_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CFG_W-1:0]    m_eff, q_eff;
   logic [CFG_W:0]      tm, tq, tm_sub, tq_sub;
   logic [CFG_W-1:0]    rm_next, rq_next, step_full;
   logic [CFG_W-1:0]    addr_sum, addr_wrap, probe_next;
   logic                bit_last, bucket_empty, bucket_match, probes_done;
   logic                req_xfer, out_free;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic [KEY_W-1:0]    mem_wdata, mem_rdata;

   dhoat_ram #(
      .WIDTH(KEY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_buckets (
      .clock(clock),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   // effective modulus values
   always_comb begin
      if (table_size_ff == '0) begin
         m_eff = CFG_W'(1);
      end else if (table_size_ff > CFG_W'(TABLE_DEPTH)) begin
         m_eff = CFG_W'(TABLE_DEPTH);
      end else begin
         m_eff = table_size_ff;
      end
      q_eff = (step_mod_ff == '0) ? CFG_W'(1) : step_mod_ff;
   end

   // one restoring-remainder step for each modulus
   always_comb begin
      tm      = {rem_m_ff, sh_ff[KEY_W-1]};
      tq      = {rem_q_ff, sh_ff[KEY_W-1]};
      tm_sub  = tm - {1'b0, m_eff};
      tq_sub  = tq - {1'b0, q_eff};
      rm_next = (tm >= {1'b0, m_eff}) ? tm_sub[CFG_W-1:0] : tm[CFG_W-1:0];
      rq_next = (tq >= {1'b0, q_eff}) ? tq_sub[CFG_W-1:0] : tq[CFG_W-1:0];
      step_full = q_eff - rq_next;
   end

   // probe walk: next bucket is (addr + step) mod m
   always_comb begin
      addr_sum     = {1'b0, addr_ff} + {1'b0, step_ff};
      addr_wrap    = (addr_sum >= m_eff) ? (addr_sum - m_eff) : addr_sum;
      probe_next   = probe_ff + CFG_W'(1);
      probes_done  = (probe_next == m_eff);
      bit_last     = (bit_cnt_ff == '0);
      bucket_empty = (mem_rdata == '0);
      bucket_match = (mem_rdata == key_ff);
      out_free     = !rsp_valid_ff || rsp_ready;
      req_xfer     = req_valid && req_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.key == '0) ? S_DONE : S_DIV;
            end
         end
         S_DIV: begin
            if (bit_last) state_in = S_STEP;
         end
         S_STEP: begin
            if (bit_last) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (bucket_empty || (op_ff == OP_SEARCH && bucket_match) || probes_done) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      mem_we    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = key_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_ff;
            mem_wdata = '0;
         end
         S_CHECK: begin
            mem_we = bucket_empty && (op_ff == OP_INSERT);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      table_size_in = table_size_ff;
      step_mod_in   = step_mod_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      sh_in         = sh_ff;
      bit_cnt_in    = bit_cnt_ff;
      rem_m_in      = rem_m_ff;
      rem_q_in      = rem_q_ff;
      addr_in       = addr_ff;
      step_in       = step_ff;
      probe_in      = probe_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SIZE:   table_size_in = csr_wdata;
            CSR_STEP_MODULUS: step_mod_in   = csr_wdata;
            default:          table_size_in = table_size_ff;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (req_xfer) begin
               op_in      = req_data.op;
               key_in     = req_data.key;
               sh_in      = req_data.key;
               bit_cnt_in = BITCNT_W'(KEY_W - 1);
               rem_m_in   = '0;
               rem_q_in   = '0;
               res_in     = '{status: STATUS_BAD_KEY, slot: '0, collisions: '0};
            end
         end
         S_DIV: begin
            sh_in      = {sh_ff[KEY_W-2:0], 1'b0};
            rem_m_in   = rm_next;
            rem_q_in   = rq_next;
            bit_cnt_in = bit_cnt_ff - BITCNT_W'(1);
            if (bit_last) begin
               // home bucket kept; now reduce the step mod m
               addr_in    = rm_next[ADDR_W-1:0];
               sh_in      = {step_full, {(KEY_W - CFG_W){1'b0}}};
               rem_m_in   = '0;
               bit_cnt_in = BITCNT_W'(CFG_W - 1);
            end
         end
         S_STEP: begin
            sh_in      = {sh_ff[KEY_W-2:0], 1'b0};
            rem_m_in   = rm_next;
            bit_cnt_in = bit_cnt_ff - BITCNT_W'(1);
            if (bit_last) begin
               step_in  = rm_next[ADDR_W-1:0];
               probe_in = '0;
            end
         end
         S_READ: begin
            probe_in = probe_ff;
         end
         S_CHECK: begin
            priority if (bucket_empty) begin
               if (op_ff == OP_INSERT) begin
                  res_in = '{status: STATUS_INSERTED, slot: addr_ff, collisions: probe_ff};
               end else begin
                  res_in = '{status: STATUS_NOT_FOUND, slot: '0, collisions: '0};
               end
            end else if (op_ff == OP_SEARCH && bucket_match) begin
               res_in = '{status: STATUS_FOUND, slot: addr_ff, collisions: '0};
            end else if (probes_done) begin
               if (op_ff == OP_INSERT) begin
                  res_in = '{status: STATUS_FULL, slot: '0, collisions: m_eff};
               end else begin
                  res_in = '{status: STATUS_NOT_FOUND, slot: '0, collisions: '0};
               end
            end else begin
               addr_in  = addr_wrap[ADDR_W-1:0];
               probe_in = probe_next;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            clr_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         table_size_ff <= TABLE_SIZE_RST;
         step_mod_ff   <= STEP_MODULUS_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         table_size_ff <= table_size_in;
         step_mod_ff   <= step_mod_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      sh_ff      <= sh_in;
      bit_cnt_ff <= bit_cnt_in;
      rem_m_ff   <= rem_m_in;
      rem_q_ff   <= rem_q_in;
      addr_ff    <= addr_in;
      step_ff    <= step_in;
      probe_ff   <= probe_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== dv/dhoat_result_check.sv =====
// Result checker for the double-hashing open-address table.
// Mirrors the bucket store and the CSRs, predicts each response and compares it.
// Depends on dhoat_pkg.
`timescale 1ns / 1ps

module dhoat_result_check
   import dhoat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int unsigned          results_owed,
   output int unsigned          fail_count
);

   logic [KEY_W-1:0] shadow_buckets [TABLE_DEPTH];
   logic [CFG_W-1:0] size_reg;
   logic [CFG_W-1:0] modulus_reg;
   rsp_type          owed_rsp [$];
   int unsigned      errors = 0;

   // Walks the probe sequence on the shadow store; inserts update it.
   function automatic rsp_type probe_buckets(req_type item);
      rsp_type     res;
      int unsigned m;
      int unsigned q;
      int unsigned home;
      int unsigned stride;
      int unsigned b;
      res.status     = STATUS_NOT_FOUND;
      res.slot       = '0;
      res.collisions = '0;
      m = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg);
      q = (modulus_reg == 0) ? 1 : modulus_reg;
      if (item.key == '0) begin
         res.status = STATUS_BAD_KEY;
         return res;
      end
      home   = item.key % m;
      stride = q - (item.key % q);
      if (item.op == OP_INSERT) res.status = STATUS_FULL;
      for (int unsigned i = 0; i < m; i++) begin
         b = (home + (i * stride) % m) % m;
         if (item.op == OP_INSERT) begin
            if (shadow_buckets[b] == '0) begin
               shadow_buckets[b] = item.key;
               res.status = STATUS_INSERTED;
               res.slot   = ADDR_W'(b);
               return res;
            end
            res.collisions = res.collisions + 1'b1;
         end else begin
            if (shadow_buckets[b] == '0) return res;
            if (shadow_buckets[b] == item.key) begin
               res.status = STATUS_FOUND;
               res.slot   = ADDR_W'(b);
               return res;
            end
         end
      end
      return res;
   endfunction

   task automatic flag(input string field, input int unsigned want, input int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int b = 0; b < TABLE_DEPTH; b++) shadow_buckets[b] = '0;
         size_reg    = TABLE_SIZE_RST;
         modulus_reg = STEP_MODULUS_RST;
         owed_rsp.delete();
      end else begin
         // compare before pushing so a same-edge request is never taken as the answer
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               $display("%0t: unexpected response, status %0d slot %0d collisions %0d",
                        $time, rsp_data.status, rsp_data.slot, rsp_data.collisions);
               errors++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  flag("status", want.status, rsp_data.status);
               if (rsp_data.slot !== want.slot)
                  flag("slot", want.slot, rsp_data.slot);
               if (rsp_data.collisions !== want.collisions)
                  flag("collisions", want.collisions, rsp_data.collisions);
            end
         end
         if (req_valid && req_ready) owed_rsp.push_back(probe_buckets(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_TABLE_SIZE:   size_reg    = csr_wdata;
               CSR_STEP_MODULUS: modulus_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      results_owed <= owed_rsp.size();
      fail_count   <= errors;
   end

endmodule

// ===== dv/tb_double_hash_open_address_table.sv =====
// Testbench top for the double-hashing open-address table.
// Drives directed and random insert/search traffic over several table configurations;
// prediction and comparison live in dhoat_result_check. Depends on dhoat_pkg.
`timescale 1ns / 1ps

module tb_double_hash_open_address_table;
   import dhoat_pkg::*;

   localparam int unsigned PHASES          = 14;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned SETTLE_CYCLES   = 100;
   localparam int unsigned WATCHDOG_LIMIT  = 20000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int unsigned      results_owed;
   int unsigned      fail_count;
   int unsigned      quiet_cycles = 0;
   bit               calm = 1'b0;
   logic [KEY_W-1:0] stored_keys [$];
   // table size per phase; mixes zero, one and oversize values and mostly grows over the run
   int unsigned      phase_size [PHASES] =
      '{12, 2047, 30, 1, 64, 0, 130, 45, 260, 6, 520, 760, 1024, 1024};

   always #5 clock = ~clock;

   double_hash_open_address_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dhoat_result_check u_result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .results_owed (results_owed),
      .fail_count   (fail_count)
   );

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 31);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Returns at the edge where the transfer happens.
   task automatic send_item(input op_type op, input logic [KEY_W-1:0] key);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, key: key};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_INSERT && key != '0) stored_keys.push_back(key);
   endtask

   task automatic write_config(input logic [CFG_W-1:0] size, input logic [CFG_W-1:0] modulus);
      csr_we    <= 1'b1;
      csr_index <= CSR_TABLE_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      csr_index <= CSR_STEP_MODULUS;
      csr_wdata <= modulus;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   initial begin
      int unsigned      roll;
      logic [KEY_W-1:0] key;
      op_type           op;
      logic [CFG_W-1:0] modulus;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // small table, zero step modulus: bad keys, collision, duplicate, fill to full
      write_config(CFG_W'(8), CFG_W'(0));
      send_item(OP_INSERT, '0);
      send_item(OP_SEARCH, '0);
      send_item(OP_INSERT, 31'h7FFF_FFFF);
      send_item(OP_INSERT, KEY_W'(5));
      send_item(OP_INSERT, KEY_W'(13));
      send_item(OP_INSERT, KEY_W'(5));
      send_item(OP_SEARCH, KEY_W'(13));
      send_item(OP_SEARCH, KEY_W'(5));
      send_item(OP_SEARCH, 31'h7FFF_FFFE);
      for (int k = 0; k < 4; k++) send_item(OP_INSERT, KEY_W'(200 + k));
      send_item(OP_INSERT, KEY_W'(77));
      send_item(OP_SEARCH, KEY_W'(99));
      drain();
      // size zero acts as one bucket
      write_config(CFG_W'(0), CFG_W'(2047));
      send_item(OP_INSERT, KEY_W'(3));
      send_item(OP_SEARCH, KEY_W'(3));
      drain();
      // oversize saturates at depth
      write_config(CFG_W'(2047), CFG_W'(1024));
      send_item(OP_INSERT, 31'h2AAA_AAAA);
      send_item(OP_SEARCH, 31'h2AAA_AAAA);
      send_item(OP_INSERT, 31'h5555_5555);
      drain();
      // shrunk table: entries above the new size are out of reach
      write_config(CFG_W'(4), CFG_W'(3));
      send_item(OP_SEARCH, KEY_W'(13));
      send_item(OP_SEARCH, KEY_W'(5));
      send_item(OP_INSERT, KEY_W'(9));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         calm <= (p == 4);
         case ($urandom_range(0, 5))
            0:       modulus = '0;
            1:       modulus = CFG_W'(1);
            2:       modulus = CFG_W'($urandom_range(2, 16));
            3:       modulus = CFG_W'($urandom_range(1, 2047));
            4:       modulus = CFG_W'(1024);
            default: modulus = CFG_W'(2047);
         endcase
         write_config(CFG_W'(phase_size[p]), modulus);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            op   = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_SEARCH;
            roll = $urandom_range(0, 99);
            if (roll < 3) key = '0;
            else if (roll < 33 && stored_keys.size() > 0)
               key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (roll < 58) key = KEY_W'($urandom_range(1, 64));
            else key = KEY_W'($urandom);
            send_item(op, key);
         end
         drain();
      end

      calm <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
